// File: src/header_framed_coordinate_parser_assert.svh
// Assertion macros for the header framed coordinate parser.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef HEADER_FRAMED_COORDINATE_PARSER_ASSERT_SVH
`define HEADER_FRAMED_COORDINATE_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define HFCP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define HFCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/hfcp_pkg.sv
// Shared types, constants and the digit combining function of the
// header framed coordinate parser. No dependencies.
`default_nettype none

package hfcp_pkg;

    localparam int BYTE_W      = 8;
    localparam int COORD_W     = 15;
    localparam int COORD_COUNT = 8;
    localparam int PAYLOAD_LEN = 24;
    localparam int DIGITS      = 3;
    localparam int COUNT_W     = 5;

    localparam logic [BYTE_W-1:0]  HDR_FIRST  = 8'h2B;
    localparam logic [BYTE_W-1:0]  HDR_SECOND = 8'h4F;
    localparam logic [COUNT_W-1:0] FRAME_LEN  = 5'd26;
    localparam logic [COUNT_W-1:0] HDR_LEN    = 5'd2;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [COORD_W-1:0] t_coord;

    typedef enum logic [1:0] {
        PH_HUNT1 = 2'd0,
        PH_HUNT2 = 2'd1,
        PH_DATA  = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    // Status of the framer for the byte it currently sees: done is set when
    // that byte is the last payload byte, and coord then holds the frame.
    typedef struct packed {
        logic                         done;
        t_coord [COORD_COUNT-1:0]     coord;
    } t_frame_result;

    // Hundreds, tens and ones combined; constant multiplies only.
    function automatic t_coord combine_digits(t_byte d0, t_byte d1, t_byte d2);
        combine_digits = COORD_W'(d0) * COORD_W'(100)
                       + COORD_W'(d1) * COORD_W'(10)
                       + COORD_W'(d2);
    endfunction

endpackage

`default_nettype wire

// File: src/header_framed_coordinate_parser.sv
// Input register, then result register, lie between a frame's last byte and its beat.
// Throughput: one byte per cycle unless stalled; each register holds one beat.
// The input stage stalls only when a completed frame meets an untaken result beat.
// Reset (i_rst_n low, synchronous) empties both registers and returns the hunt to the
// first header; the payload line is not cleared, every entry is rewritten per frame.
`default_nettype none

`include "header_framed_coordinate_parser_assert.svh"

module header_framed_coordinate_parser (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Receive side: one serial byte per beat.
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire  [7:0]                         i_s_axis_tdata,   // [7:0] rx_byte
    // Result side: one beat per complete frame.
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // [14:0] point1_x, [29:15] point1_y, [44:30] point2_x, [59:45] point2_y,
    // [74:60] point3_x, [89:75] point3_y, [104:90] point4_x, [119:105] point4_y
    output logic [119:0]                       o_m_axis_tdata
);
    import hfcp_pkg::*;

    // Input register: holds one received byte until the framer takes it.
    logic          r_in_valid;
    t_byte         r_in_byte;

    // Result register: holds one frame's coordinates until the sink takes it.
    logic          r_out_valid;
    t_coord [COORD_COUNT-1:0] r_out_coord;

    t_frame_result w_res;
    logic          w_in_consume;
    logic          w_load;

    // The framer takes the registered byte unless that byte completes a frame
    // while the previous result beat is still waiting for the sink.
    assign w_in_consume = r_in_valid
                          && (!w_res.done || !r_out_valid || i_m_axis_tready);
    assign w_load       = w_in_consume && w_res.done;

    assign o_s_axis_tready = !r_in_valid || w_in_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    hfcp_framer u_framer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_in_consume),
        .i_byte   (r_in_byte),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_coord <= w_res.coord;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_coord;

    // A result beat appears only when a frame has just completed.
    `HFCP_ASSERT_NEXT(a_no_spurious_result, !r_out_valid && !w_load, !r_out_valid, "result beat without a completed frame")
    // A held input byte is neither lost nor altered while the framer waits.
    `HFCP_ASSERT_NEXT(a_input_held, r_in_valid && !w_in_consume, r_in_valid && $stable(r_in_byte), "stalled input byte lost")
    // A new result never overwrites one the sink has not taken.
    `HFCP_ASSERT_SAME(a_no_overwrite, w_load, !r_out_valid || i_m_axis_tready, "pending result overwritten")

endmodule

`default_nettype wire

// File: src/hfcp_framer.sv
// Header hunt state machine, payload shift line and coordinate conversion.
// Depends on hfcp_pkg.
`default_nettype none

module hfcp_framer (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_step,
    input  wire hfcp_pkg::t_byte   i_byte,
    output hfcp_pkg::t_frame_result o_result
);
    import hfcp_pkg::*;

    localparam int STORE_LEN = PAYLOAD_LEN - 1;

    t_phase              r_phase, n_phase;
    logic [COUNT_W-1:0]  r_count, n_count;
    t_byte               r_store [STORE_LEN];
    t_byte               w_payload [PAYLOAD_LEN];
    logic                w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_phase = PH_HUNT1;
        n_count = '0;
        w_last  = 1'b0;
        case (r_phase)
            PH_HUNT1: begin
                if (i_byte == HDR_FIRST) begin
                    n_phase = PH_HUNT2;
                    n_count = COUNT_W'(1);
                end
            end
            PH_HUNT2: begin
                if (i_byte == HDR_SECOND) begin
                    n_phase = PH_DATA;
                    n_count = HDR_LEN;
                end
            end
            PH_DATA: begin
                n_phase = PH_DATA;
                n_count = r_count + COUNT_W'(1);
                if (r_count == FRAME_LEN - COUNT_W'(1)) begin
                    n_phase = PH_DONE;
                    w_last  = 1'b1;
                end
            end
            default: begin
                n_phase = PH_HUNT1;
                n_count = '0;
            end
        endcase
    end

    // Payload bytes move down the line; the oldest sits at index 0.
    always_ff @(posedge i_clk) begin
        if (i_step && r_phase == PH_DATA) begin
            for (int k = 0; k < STORE_LEN - 1; k++) begin
                r_store[k] <= r_store[k + 1];
            end
            r_store[STORE_LEN - 1] <= i_byte;
        end
    end

    always_comb begin
        for (int k = 0; k < STORE_LEN; k++) begin
            w_payload[k] = r_store[k];
        end
        w_payload[PAYLOAD_LEN - 1] = i_byte;
    end

    always_comb begin
        o_result.done = w_last;
        for (int c = 0; c < COORD_COUNT; c++) begin
            o_result.coord[c] = combine_digits(w_payload[c * DIGITS],
                                               w_payload[c * DIGITS + 1],
                                               w_payload[c * DIGITS + 2]);
        end
    end

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for header_framed_coordinate_parser: drives serial bytes as stream
// beats, predicts each completed frame's eight coordinates and checks every result beat.
// Depends on hfcp_pkg and the parser RTL only.
`timescale 1ns / 100ps

module tb_top;

    import hfcp_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int QUIET_TAIL  = 150;     // last bytes are sent with no idling on either side
    localparam int DRAIN_WAIT  = 8;       // cycles after the last result, well above latency
    localparam int RUN_LIMIT   = 2000000; // ns

    // One packed set of the eight coordinates, point1_x in the lowest slot like tdata.
    typedef t_coord [COORD_COUNT-1:0] t_point_set;

    // A backlog entry is either a byte to send or a pause until all results are in.
    typedef struct {
        bit    hold;
        t_byte data;
    } t_rx_entry;

    logic         i_clk   = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    t_byte        s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;

    header_framed_coordinate_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [7:0] rx_byte
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)    // point1_x .. point4_y, 15 bits each from bit 0 up
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    t_rx_entry  byte_backlog[$];
    t_point_set frames_due[$];

    int beats_offered = 0;
    int beats_taken   = 0;
    int frames_seen   = 0;
    int hunt_rejects  = 0;
    int errors        = 0;

    // Parser state as the bench believes it to be.
    t_phase     rx_phase = PH_HUNT1;
    logic [4:0] rx_count = '0;
    t_byte      payload [PAYLOAD_LEN];

    task automatic flag_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        errors++;
    endtask

    // Advance the parser state by one received byte; a finished frame queues its
    // coordinate set. The byte after a frame is swallowed whatever its value, and a
    // wrong second header byte is not looked at again as a first header.
    task automatic parse_rx_byte(input t_byte b);
        t_point_set pts;
        case (rx_phase)
            PH_HUNT1: begin
                if (b == HDR_FIRST) begin
                    rx_phase = PH_HUNT2;
                    rx_count = 5'd1;
                end else begin
                    rx_count = '0;
                    hunt_rejects++;
                end
            end
            PH_HUNT2: begin
                if (b == HDR_SECOND) begin
                    rx_phase = PH_DATA;
                    rx_count = HDR_LEN;
                end else begin
                    rx_phase = PH_HUNT1;
                    rx_count = '0;
                    hunt_rejects++;
                end
            end
            PH_DATA: begin
                payload[rx_count - HDR_LEN] = b;
                rx_count = rx_count + 5'd1;
                if (rx_count == FRAME_LEN) begin
                    rx_phase = PH_DONE;
                    for (int k = 0; k < COORD_COUNT; k++) begin
                        pts[k] = COORD_W'(int'(payload[3*k]) * 100
                                        + int'(payload[3*k+1]) * 10
                                        + int'(payload[3*k+2]));
                    end
                    frames_due.push_back(pts);
                end
            end
            default: begin
                rx_phase = PH_HUNT1;
                rx_count = '0;
            end
        endcase
    endtask

    function automatic int pick_idle_pct();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 15;
            default: return 50;
        endcase
    endfunction

    function automatic bit quiet_tail();
        return byte_backlog.size() < QUIET_TAIL;
    endfunction

    // Sender: a new beat is put up at the falling edge once the previous one is taken.
    int src_gap       = 0;
    int src_idle_pct  = 0;
    int src_mode_left = 0;

    always @(negedge i_clk) begin
        logic      nv;
        t_byte     nd;
        t_rx_entry ent;
        nv = s_tvalid;
        nd = s_tdata;
        if (src_mode_left == 0) begin
            src_mode_left = 64;
            src_idle_pct  = pick_idle_pct();
        end else begin
            src_mode_left--;
        end
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (beats_taken == beats_offered) begin
            nv = 1'b0;
            if (src_gap > 0) begin
                src_gap--;
            end else if (byte_backlog.size() > 0) begin
                if (byte_backlog[0].hold) begin
                    // Hold the line until every predicted frame has come out.
                    if (frames_due.size() == 0)
                        void'(byte_backlog.pop_front());
                end else if (!quiet_tail() && $urandom_range(99) < src_idle_pct) begin
                    src_gap = $urandom_range(4);
                end else begin
                    ent = byte_backlog.pop_front();
                    nd  = ent.data;
                    nv  = 1'b1;
                    beats_offered++;
                end
            end
        end
        s_tvalid <= nv;
        s_tdata  <= nd;
    end

    // Receiver: result beats are stalled in bursts as well.
    int sink_gap       = 0;
    int sink_idle_pct  = 0;
    int sink_mode_left = 0;

    always @(negedge i_clk) begin
        logic nr;
        if (sink_mode_left == 0) begin
            sink_mode_left = 48;
            sink_idle_pct  = pick_idle_pct();
        end else begin
            sink_mode_left--;
        end
        if (!i_rst_n) begin
            nr = 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            nr = 1'b0;
        end else if (!quiet_tail() && $urandom_range(99) < sink_idle_pct) begin
            sink_gap = $urandom_range(4);
            nr = 1'b0;
        end else begin
            nr = 1'b1;
        end
        m_tready <= nr;
    end

    // Monitor: both handshakes are sampled at the rising edge.
    always @(posedge i_clk) begin
        t_point_set want;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (frames_due.size() == 0) begin
                    flag_error("result beat with no frame outstanding");
                end else begin
                    want = frames_due.pop_front();
                    for (int k = 0; k < COORD_COUNT; k++) begin
                        if (m_tdata[k*COORD_W +: COORD_W] !== want[k])
                            flag_error($sformatf("frame %0d point%0d_%s: got %0d, want %0d",
                                frames_seen, k/2 + 1, (k % 2) ? "y" : "x",
                                m_tdata[k*COORD_W +: COORD_W], want[k]));
                    end
                end
                frames_seen++;
            end
            if (s_tvalid && s_tready) begin
                parse_rx_byte(s_tdata);
                beats_taken++;
            end
        end
    end

    task automatic push_byte(input t_byte b);
        t_rx_entry e;
        e.hold = 1'b0;
        e.data = b;
        byte_backlog.push_back(e);
    endtask

    task automatic push_hold();
        t_rx_entry e;
        e.hold = 1'b1;
        e.data = '0;
        byte_backlog.push_back(e);
    endtask

    // Mostly decimal digits, now and then any byte value.
    function automatic t_byte random_digit();
        if ($urandom_range(3) != 0)
            return t_byte'($urandom_range(9));
        return t_byte'($urandom_range(255));
    endfunction

    // Noise leans toward the header values so near-misses happen often.
    function automatic t_byte random_noise();
        case ($urandom_range(3))
            0:       return HDR_FIRST;
            1:       return HDR_SECOND;
            default: return t_byte'($urandom_range(255));
        endcase
    endfunction

    task automatic push_random_frame();
        push_byte(HDR_FIRST);
        push_byte(HDR_SECOND);
        for (int i = 0; i < PAYLOAD_LEN; i++)
            push_byte(random_digit());
    endtask

    int planned_frames = 0;

    initial begin
        int pick;

        // Directed: wrong first header, a repeated first header that must not be
        // taken as a new start, a lone second header, then a frame whose digits hit
        // zero and the top byte value, followed by a header byte that gets swallowed.
        push_byte(8'h00);
        push_byte(HDR_FIRST);
        push_byte(HDR_FIRST);
        push_byte(HDR_SECOND);
        push_byte(8'hFF);
        push_byte(HDR_FIRST);
        push_byte(HDR_SECOND);
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            case (i % 6)
                0, 1, 2: push_byte(8'hFF);
                3:       push_byte(8'h00);
                4:       push_byte(8'h80);
                default: push_byte(t_byte'(i));
            endcase
        end
        push_byte(HDR_FIRST);
        push_byte(HDR_SECOND);
        push_hold();

        // Random: mostly well-formed frames with random digits, plus broken
        // headers, noise, and frames run back to back with no spare byte between.
        while (byte_backlog.size() < 1200 || planned_frames < 40) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                push_random_frame();
                push_byte(($urandom_range(3) == 0) ? HDR_FIRST : t_byte'($urandom_range(255)));
                planned_frames++;
            end else if (pick < 78) begin
                push_byte(HDR_FIRST);
                push_byte(($urandom_range(1) == 0) ? HDR_FIRST
                                                   : (t_byte'($urandom_range(255)) ^ 8'h01));
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 4)) push_byte(random_noise());
            end else begin
                push_random_frame();
                planned_frames++;
            end
            if (planned_frames == 20)
                push_hold();
        end

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        do @(posedge i_clk);
        while (byte_backlog.size() != 0 || beats_taken != beats_offered || frames_due.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d bytes (%0d bytes dropped while hunting for a header).",
                 beats_taken, hunt_rejects);
        $display("Checked %0d frames field by field, %0d mismatches.", frames_seen, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("Timeout with %0d frames still outstanding.", frames_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
